// File: design/etmr_pkg.sv
// Package for the exponent-table mixing round: shared types, the
// 45^n mod 257 table and the bytewise point operation. No dependencies.
package etmr_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned NumBytes = WordW / ByteW;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;

  // 45^n mod 257, with 256 written as 0
  function automatic byte_t exp45(input byte_t n);
    byte_t r;
    case (n)
      8'd0: r = 8'd1; 8'd1: r = 8'd45; 8'd2: r = 8'd226; 8'd3: r = 8'd147;
      8'd4: r = 8'd190; 8'd5: r = 8'd69; 8'd6: r = 8'd21; 8'd7: r = 8'd174;
      8'd8: r = 8'd120; 8'd9: r = 8'd3; 8'd10: r = 8'd135; 8'd11: r = 8'd164;
      8'd12: r = 8'd184; 8'd13: r = 8'd56; 8'd14: r = 8'd207; 8'd15: r = 8'd63;
      8'd16: r = 8'd8; 8'd17: r = 8'd103; 8'd18: r = 8'd9; 8'd19: r = 8'd148;
      8'd20: r = 8'd235; 8'd21: r = 8'd38; 8'd22: r = 8'd168; 8'd23: r = 8'd107;
      8'd24: r = 8'd189; 8'd25: r = 8'd24; 8'd26: r = 8'd52; 8'd27: r = 8'd27;
      8'd28: r = 8'd187; 8'd29: r = 8'd191; 8'd30: r = 8'd114; 8'd31: r = 8'd247;
      8'd32: r = 8'd64; 8'd33: r = 8'd53; 8'd34: r = 8'd72; 8'd35: r = 8'd156;
      8'd36: r = 8'd81; 8'd37: r = 8'd47; 8'd38: r = 8'd59; 8'd39: r = 8'd85;
      8'd40: r = 8'd227; 8'd41: r = 8'd192; 8'd42: r = 8'd159; 8'd43: r = 8'd216;
      8'd44: r = 8'd211; 8'd45: r = 8'd243; 8'd46: r = 8'd141; 8'd47: r = 8'd177;
      8'd48: r = 8'd255; 8'd49: r = 8'd167; 8'd50: r = 8'd62; 8'd51: r = 8'd220;
      8'd52: r = 8'd134; 8'd53: r = 8'd119; 8'd54: r = 8'd215; 8'd55: r = 8'd166;
      8'd56: r = 8'd17; 8'd57: r = 8'd251; 8'd58: r = 8'd244; 8'd59: r = 8'd186;
      8'd60: r = 8'd146; 8'd61: r = 8'd145; 8'd62: r = 8'd100; 8'd63: r = 8'd131;
      8'd64: r = 8'd241; 8'd65: r = 8'd51; 8'd66: r = 8'd239; 8'd67: r = 8'd218;
      8'd68: r = 8'd44; 8'd69: r = 8'd181; 8'd70: r = 8'd178; 8'd71: r = 8'd43;
      8'd72: r = 8'd136; 8'd73: r = 8'd209; 8'd74: r = 8'd153; 8'd75: r = 8'd203;
      8'd76: r = 8'd140; 8'd77: r = 8'd132; 8'd78: r = 8'd29; 8'd79: r = 8'd20;
      8'd80: r = 8'd129; 8'd81: r = 8'd151; 8'd82: r = 8'd113; 8'd83: r = 8'd202;
      8'd84: r = 8'd95; 8'd85: r = 8'd163; 8'd86: r = 8'd139; 8'd87: r = 8'd87;
      8'd88: r = 8'd60; 8'd89: r = 8'd130; 8'd90: r = 8'd196; 8'd91: r = 8'd82;
      8'd92: r = 8'd92; 8'd93: r = 8'd28; 8'd94: r = 8'd232; 8'd95: r = 8'd160;
      8'd96: r = 8'd4; 8'd97: r = 8'd180; 8'd98: r = 8'd133; 8'd99: r = 8'd74;
      8'd100: r = 8'd246; 8'd101: r = 8'd19; 8'd102: r = 8'd84; 8'd103: r = 8'd182;
      8'd104: r = 8'd223; 8'd105: r = 8'd12; 8'd106: r = 8'd26; 8'd107: r = 8'd142;
      8'd108: r = 8'd222; 8'd109: r = 8'd224; 8'd110: r = 8'd57; 8'd111: r = 8'd252;
      8'd112: r = 8'd32; 8'd113: r = 8'd155; 8'd114: r = 8'd36; 8'd115: r = 8'd78;
      8'd116: r = 8'd169; 8'd117: r = 8'd152; 8'd118: r = 8'd158; 8'd119: r = 8'd171;
      8'd120: r = 8'd242; 8'd121: r = 8'd96; 8'd122: r = 8'd208; 8'd123: r = 8'd108;
      8'd124: r = 8'd234; 8'd125: r = 8'd250; 8'd126: r = 8'd199; 8'd127: r = 8'd217;
      8'd128: r = 8'd0; 8'd129: r = 8'd212; 8'd130: r = 8'd31; 8'd131: r = 8'd110;
      8'd132: r = 8'd67; 8'd133: r = 8'd188; 8'd134: r = 8'd236; 8'd135: r = 8'd83;
      8'd136: r = 8'd137; 8'd137: r = 8'd254; 8'd138: r = 8'd122; 8'd139: r = 8'd93;
      8'd140: r = 8'd73; 8'd141: r = 8'd201; 8'd142: r = 8'd50; 8'd143: r = 8'd194;
      8'd144: r = 8'd249; 8'd145: r = 8'd154; 8'd146: r = 8'd248; 8'd147: r = 8'd109;
      8'd148: r = 8'd22; 8'd149: r = 8'd219; 8'd150: r = 8'd89; 8'd151: r = 8'd150;
      8'd152: r = 8'd68; 8'd153: r = 8'd233; 8'd154: r = 8'd205; 8'd155: r = 8'd230;
      8'd156: r = 8'd70; 8'd157: r = 8'd66; 8'd158: r = 8'd143; 8'd159: r = 8'd10;
      8'd160: r = 8'd193; 8'd161: r = 8'd204; 8'd162: r = 8'd185; 8'd163: r = 8'd101;
      8'd164: r = 8'd176; 8'd165: r = 8'd210; 8'd166: r = 8'd198; 8'd167: r = 8'd172;
      8'd168: r = 8'd30; 8'd169: r = 8'd65; 8'd170: r = 8'd98; 8'd171: r = 8'd41;
      8'd172: r = 8'd46; 8'd173: r = 8'd14; 8'd174: r = 8'd116; 8'd175: r = 8'd80;
      8'd176: r = 8'd2; 8'd177: r = 8'd90; 8'd178: r = 8'd195; 8'd179: r = 8'd37;
      8'd180: r = 8'd123; 8'd181: r = 8'd138; 8'd182: r = 8'd42; 8'd183: r = 8'd91;
      8'd184: r = 8'd240; 8'd185: r = 8'd6; 8'd186: r = 8'd13; 8'd187: r = 8'd71;
      8'd188: r = 8'd111; 8'd189: r = 8'd112; 8'd190: r = 8'd157; 8'd191: r = 8'd126;
      8'd192: r = 8'd16; 8'd193: r = 8'd206; 8'd194: r = 8'd18; 8'd195: r = 8'd39;
      8'd196: r = 8'd213; 8'd197: r = 8'd76; 8'd198: r = 8'd79; 8'd199: r = 8'd214;
      8'd200: r = 8'd121; 8'd201: r = 8'd48; 8'd202: r = 8'd104; 8'd203: r = 8'd54;
      8'd204: r = 8'd117; 8'd205: r = 8'd125; 8'd206: r = 8'd228; 8'd207: r = 8'd237;
      8'd208: r = 8'd128; 8'd209: r = 8'd106; 8'd210: r = 8'd144; 8'd211: r = 8'd55;
      8'd212: r = 8'd162; 8'd213: r = 8'd94; 8'd214: r = 8'd118; 8'd215: r = 8'd170;
      8'd216: r = 8'd197; 8'd217: r = 8'd127; 8'd218: r = 8'd61; 8'd219: r = 8'd175;
      8'd220: r = 8'd165; 8'd221: r = 8'd229; 8'd222: r = 8'd25; 8'd223: r = 8'd97;
      8'd224: r = 8'd253; 8'd225: r = 8'd77; 8'd226: r = 8'd124; 8'd227: r = 8'd183;
      8'd228: r = 8'd11; 8'd229: r = 8'd238; 8'd230: r = 8'd173; 8'd231: r = 8'd75;
      8'd232: r = 8'd34; 8'd233: r = 8'd245; 8'd234: r = 8'd231; 8'd235: r = 8'd115;
      8'd236: r = 8'd35; 8'd237: r = 8'd33; 8'd238: r = 8'd200; 8'd239: r = 8'd5;
      8'd240: r = 8'd225; 8'd241: r = 8'd102; 8'd242: r = 8'd221; 8'd243: r = 8'd179;
      8'd244: r = 8'd88; 8'd245: r = 8'd105; 8'd246: r = 8'd99; 8'd247: r = 8'd86;
      8'd248: r = 8'd15; 8'd249: r = 8'd161; 8'd250: r = 8'd49; 8'd251: r = 8'd149;
      8'd252: r = 8'd23; 8'd253: r = 8'd7; 8'd254: r = 8'd58; 8'd255: r = 8'd40;
      default: r = 8'd1;
    endcase
    return r;
  endfunction

  // bytewise point operation: exp45 of each byte of x xor that of y
  function automatic word_t point(input word_t x, input word_t y);
    word_t r;
    r = '0;
    for (int i = 0; i < NumBytes; i++) begin
      r[i*ByteW +: ByteW] = exp45(x[i*ByteW +: ByteW]) ^ exp45(y[i*ByteW +: ByteW]);
    end
    return r;
  endfunction

endpackage

// File: design/etmr_key_stage.sv
// Keying stage of the round: a1 = point(half_a, key_a), b1 = half_b + key_b.
// Depends on etmr_pkg.
module etmr_key_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  etmr_pkg::word_t half_a_i,
  input  etmr_pkg::word_t half_b_i,
  input  etmr_pkg::word_t key_a_i,
  input  etmr_pkg::word_t key_b_i,
  input  etmr_pkg::word_t key_e_i,
  input  etmr_pkg::word_t key_f_i,
  output logic           valid_o,
  output etmr_pkg::word_t a1_o,
  output etmr_pkg::word_t b1_o,
  output etmr_pkg::word_t key_e_o,
  output etmr_pkg::word_t key_f_o
);
  import etmr_pkg::*;

  logic  valid_q;
  word_t a1_q, b1_q, ke_q, kf_q;

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      a1_q <= point(half_a_i, key_a_i);
      b1_q <= half_b_i + key_b_i;
      ke_q <= key_e_i;
      kf_q <= key_f_i;
    end
  end

  assign valid_o = valid_q;
  assign a1_o    = a1_q;
  assign b1_o    = b1_q;
  assign key_e_o = ke_q;
  assign key_f_o = kf_q;
endmodule

// File: design/etmr_mix_stage.sv
// Mixing stages: y1/z1, then the inner point sum and key_e term, then
// y2, then the final sums. Depends on etmr_pkg.
module etmr_mix_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  etmr_pkg::word_t a1_i,
  input  etmr_pkg::word_t b1_i,
  input  etmr_pkg::word_t key_e_i,
  input  etmr_pkg::word_t key_f_i,
  output logic           valid_o,
  output etmr_pkg::word_t out_a_o,
  output etmr_pkg::word_t out_b_o
);
  import etmr_pkg::*;

  logic [3:0] vld_q;
  // stage 1: y1, z1
  word_t s1_a1_q, s1_b1_q, s1_y1_q, s1_z1_q, s1_ke_q, s1_kf_q;
  // stage 2: inner sum and key_e point
  word_t s2_a1_q, s2_b1_q, s2_in_q, s2_pe_q, s2_kf_q;
  // stage 3: y2
  word_t s3_a1_q, s3_b1_q, s3_pe_q, s3_y2_q;
  // stage 4: outputs
  word_t oa_q, ob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s1_a1_q <= a1_i;
      s1_b1_q <= b1_i;
      s1_y1_q <= a1_i ^ b1_i;
      s1_z1_q <= a1_i + b1_i;
      s1_ke_q <= key_e_i;
      s1_kf_q <= key_f_i;
    end
    if (vld_q[0]) begin
      s2_a1_q <= s1_a1_q;
      s2_b1_q <= s1_b1_q;
      s2_in_q <= point(s1_a1_q, s1_y1_q) + s1_z1_q;
      s2_pe_q <= point(s1_ke_q, s1_y1_q);
      s2_kf_q <= s1_kf_q;
    end
    if (vld_q[1]) begin
      s3_a1_q <= s2_a1_q;
      s3_b1_q <= s2_b1_q;
      s3_pe_q <= s2_pe_q;
      s3_y2_q <= point(s2_in_q, s2_kf_q);
    end
    if (vld_q[2]) begin
      oa_q <= s3_a1_q + s3_y2_q;
      ob_q <= s3_b1_q + s3_pe_q + s3_y2_q;
    end
  end

  assign valid_o = vld_q[3];
  assign out_a_o = oa_q;
  assign out_b_o = ob_q;
endmodule

// File: design/exp_table_mixing_round.sv
// Top level of the exponent-table mixing round.
// Depends on etmr_pkg, etmr_key_stage, etmr_mix_stage.

// One full round of a 128-bit block cipher with the 45^n mod 257 point
// operation. Pulse start with the inputs; busy is always low, so an item
// is taken every cycle. Each result appears for one cycle, with done_o
// high; the datapath has five register stages: the key stage and four
// mixing stages. The receiver cannot stall the block.
module exp_table_mixing_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  etmr_pkg::word_t half_a_i,
  input  etmr_pkg::word_t half_b_i,
  input  etmr_pkg::word_t key_a_i,
  input  etmr_pkg::word_t key_b_i,
  input  etmr_pkg::word_t key_e_i,
  input  etmr_pkg::word_t key_f_i,
  output logic           done_o,
  output etmr_pkg::word_t out_a_o,
  output etmr_pkg::word_t out_b_o
);
  import etmr_pkg::*;

  logic  k_valid;
  word_t a1, b1, ke, kf;

  assign busy = 1'b0;

  etmr_key_stage u_key (
    .clk_i, .rst_ni,
    .valid_i (start),
    .half_a_i, .half_b_i, .key_a_i, .key_b_i, .key_e_i, .key_f_i,
    .valid_o (k_valid),
    .a1_o (a1), .b1_o (b1), .key_e_o (ke), .key_f_o (kf)
  );

  etmr_mix_stage u_mix (
    .clk_i, .rst_ni,
    .valid_i (k_valid),
    .a1_i (a1), .b1_i (b1), .key_e_i (ke), .key_f_i (kf),
    .valid_o (done_o),
    .out_a_o, .out_b_o
  );

`ifndef SYNTHESIS
  // every item must be followed by its result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##5 done_o) else $error("missing result");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(k_valid, 4)) else $error("spurious result");
`endif
endmodule
